@@ rtl/cdcnr_pkg.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcnr_pkg
// Shared widths, constants and types for the CDC notification reassembler.
// ----------------------------------------------------------------------------
package cdcnr_pkg;

  localparam int CNT_W = 17;          // byte counters and lengths
  localparam int TOT_W = CNT_W + 1;   // sum of two counters
  localparam int LEN_W = 7;           // emitted message length

  localparam logic [CNT_W-1:0] CNT_MAX   = {CNT_W{1'b1}};
  localparam logic [CNT_W-1:0] HDR_BYTES = CNT_W'(8);
  localparam logic [7:0]       REQ_TYPE  = 8'hA1;

  typedef logic [CNT_W-1:0] cnt_t;
  typedef logic [TOT_W-1:0] tot_t;
  typedef logic [LEN_W-1:0] len_t;

endpackage

@@ rtl/cdcnr_front.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcnr_front
// Takes fragment bytes, writes them into the store, tracks fragment and
// message counts, and posts a drain request when a notification completes.
// ----------------------------------------------------------------------------
module cdcnr_front
  import cdcnr_pkg::*;
#(
  parameter int BUF_BYTES = 64,
  localparam int AW = $clog2(BUF_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_stall,
  input  logic [7:0]    data_byte,
  input  logic          carries_byte,
  input  logic          frag_end,
  input  logic          hold,
  output logic          wr_en,
  output logic [AW-1:0] wr_addr,
  output logic [7:0]    wr_data,
  output logic          push,
  output len_t          push_len
);

  cnt_t       committed;
  cnt_t       expected;
  cnt_t       fcount;
  logic [7:0] hdr0;
  logic [7:0] hdr6;
  logic [7:0] hdr7;

  logic       accept;
  tot_t       pos;
  cnt_t       fcount_inc;
  cnt_t       len;
  logic [7:0] h0;
  logic [7:0] h6;
  logic [7:0] h7;
  logic       first;
  cnt_t       exp_len;
  tot_t       total;
  logic       bad_first;
  logic       short_msg;
  logic       cont;
  logic       emit;

  assign in_stall = hold;
  assign accept   = in_valid && !hold;

  assign pos        = {1'b0, committed} + {1'b0, fcount};
  assign fcount_inc = (fcount == CNT_MAX) ? fcount : fcount + cnt_t'(1);
  assign len        = carries_byte ? fcount_inc : fcount;

  assign wr_en   = accept && carries_byte && (pos < tot_t'(BUF_BYTES));
  assign wr_addr = pos[AW-1:0];
  assign wr_data = data_byte;

  // header bytes as they stand after this item
  assign h0 = (carries_byte && pos == tot_t'(0)) ? data_byte : hdr0;
  assign h6 = (carries_byte && pos == tot_t'(6)) ? data_byte : hdr6;
  assign h7 = (carries_byte && pos == tot_t'(7)) ? data_byte : hdr7;

  assign first     = (committed == '0);
  assign exp_len   = first ? (HDR_BYTES + {1'b0, h7, h6}) : expected;
  assign total     = first ? {1'b0, len} : ({1'b0, committed} + {1'b0, len});
  assign bad_first = first && ((len < HDR_BYTES) || (len > cnt_t'(BUF_BYTES)) ||
                               (h0 != REQ_TYPE));
  assign short_msg = total < {1'b0, exp_len};
  assign cont      = !bad_first && short_msg && (len != '0);
  assign emit      = !bad_first && (total == {1'b0, exp_len}) &&
                     (total <= tot_t'(BUF_BYTES));

  assign push     = accept && frag_end && emit;
  assign push_len = total[LEN_W-1:0];

  always_ff @(posedge clk) begin
    if (rst) begin
      committed <= '0;
      expected  <= '0;
      fcount    <= '0;
    end else if (accept) begin
      if (frag_end) begin
        fcount <= '0;
        if (cont) begin
          committed <= total[CNT_W-1:0];
          expected  <= exp_len;
        end else begin
          committed <= '0;
          expected  <= '0;
        end
      end else if (carries_byte) begin
        fcount <= fcount_inc;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      hdr0 <= h0;
      hdr6 <= h6;
      hdr7 <= h7;
    end
  end

endmodule

@@ rtl/cdcnr_queue.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcnr_queue
// Two-entry queue of drain requests between the front and the drain side.
// ----------------------------------------------------------------------------
module cdcnr_queue
  import cdcnr_pkg::*;
(
  input  logic clk,
  input  logic rst,
  input  logic push,
  input  len_t push_len,
  input  logic pop,
  output logic not_empty,
  output len_t pop_len
);

  localparam int DEPTH = 2;
  localparam int PW    = $clog2(DEPTH);

  len_t              entries [DEPTH];
  logic [PW-1:0]     wr_ptr;
  logic [PW-1:0]     rd_ptr;
  logic [PW:0]       count;
  logic              do_push;
  logic              do_pop;

  assign not_empty = (count != '0);
  assign pop_len   = entries[rd_ptr];
  assign do_push   = push && (count != (PW+1)'(DEPTH));
  assign do_pop    = pop && not_empty;

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + PW'(1);
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + PW'(1);
      end
      if (do_push && !do_pop) begin
        count <= count + (PW+1)'(1);
      end else if (do_pop && !do_push) begin
        count <= count - (PW+1)'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= push_len;
    end
  end

endmodule

@@ rtl/cdcnr_drain.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdcnr_drain
// Holds the reassembly store and plays a completed notification out of it
// byte by byte, each through a registered store read and a registered output.
// ----------------------------------------------------------------------------
module cdcnr_drain
  import cdcnr_pkg::*;
#(
  parameter int BUF_BYTES = 64,
  localparam int AW = $clog2(BUF_BYTES)
) (
  input  logic          clk,
  input  logic          rst,
  input  logic          wr_en,
  input  logic [AW-1:0] wr_addr,
  input  logic [7:0]    wr_data,
  input  logic          q_valid,
  input  len_t          q_len,
  output logic          q_pop,
  output logic          busy,
  output logic          out_valid,
  input  logic          out_stall,
  output logic [7:0]    msg_byte,
  output logic          msg_last,
  output len_t          msg_length
);

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_READ = 2'd1;
  localparam logic [1:0] S_LOAD = 2'd2;

  logic [7:0]    mem [BUF_BYTES];
  logic [7:0]    rdata;
  logic [1:0]    state;
  logic [AW-1:0] idx;
  len_t          total;
  logic          last;
  logic          can_load;

  assign busy     = (state != S_IDLE);
  assign q_pop    = (state == S_IDLE) && q_valid;
  assign last     = (len_t'(idx) + len_t'(1)) == total;
  assign can_load = !out_valid || !out_stall;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (state == S_READ) begin
      rdata <= mem[idx];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      // load a new byte, or let a taken one go
      if (state == S_LOAD && can_load) begin
        out_valid <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
      unique case (state)
        S_IDLE: begin
          if (q_valid) begin
            state <= S_READ;
          end
        end
        S_READ: begin
          state <= S_LOAD;
        end
        S_LOAD: begin
          if (can_load) begin
            state <= last ? S_IDLE : S_READ;
          end
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (state == S_IDLE && q_valid) begin
      total <= q_len;
      idx   <= '0;
    end
    if (state == S_LOAD && can_load) begin
      msg_byte   <= rdata;
      msg_last   <= last;
      msg_length <= total;
      idx        <= idx + AW'(1);
    end
  end

endmodule

@@ rtl/cdc_notification_reassembler.sv @@
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// cdc_notification_reassembler
// Rebuilds CDC class notifications from interrupt-endpoint fragments.
// ----------------------------------------------------------------------------
// Input items are single fragment bytes (or bare end marks). The front takes
// one item per cycle while no finished notification waits or drains. A message
// starts only with a fragment of 8 to BUF_BYTES bytes whose first byte is
// 0xA1; its length is 8 plus the little-endian wLength in bytes 6 and 7.
// When the counted bytes reach that length and the message fit in the
// store, it is played out one output item per byte, each carrying msg_last
// and the total msg_length. While a request waits or a message drains, in_stall
// is held high: the drain picks up the request, then for each byte does a
// registered store read and then the output register load, so a completed
// message blocks input until its last byte is loaded, longer if out_stall
// holds the output register. The store has no reset and needs no clearing
// pass; header bytes are taken from the current first fragment.
// ----------------------------------------------------------------------------
module cdc_notification_reassembler
  import cdcnr_pkg::*;
#(
  parameter int BUF_BYTES = 64
) (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [7:0] data_byte,
  input  logic       carries_byte,
  input  logic       frag_end,
  output logic       out_valid,
  input  logic       out_stall,
  output logic [7:0] msg_byte,
  output logic       msg_last,
  output logic [6:0] msg_length
);

  localparam int AW = $clog2(BUF_BYTES);

  // store write port, driven by the front
  logic          wr_en;
  logic [AW-1:0] wr_addr;
  logic [7:0]    wr_data;

  // drain requests
  logic          push;
  len_t          push_len;
  logic          q_valid;
  len_t          q_len;
  logic          q_pop;
  logic          busy;

  // the front holds off while a request waits or a drain runs, so the
  // store is never overwritten under a message being played out
  logic          hold;
  assign hold = q_valid || busy;

  cdcnr_front #(
    .BUF_BYTES (BUF_BYTES)
  ) u_front (
    .clk          (clk),
    .rst          (rst),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .data_byte    (data_byte),
    .carries_byte (carries_byte),
    .frag_end     (frag_end),
    .hold         (hold),
    .wr_en        (wr_en),
    .wr_addr      (wr_addr),
    .wr_data      (wr_data),
    .push         (push),
    .push_len     (push_len)
  );

  cdcnr_queue u_queue (
    .clk       (clk),
    .rst       (rst),
    .push      (push),
    .push_len  (push_len),
    .pop       (q_pop),
    .not_empty (q_valid),
    .pop_len   (q_len)
  );

  cdcnr_drain #(
    .BUF_BYTES (BUF_BYTES)
  ) u_drain (
    .clk        (clk),
    .rst        (rst),
    .wr_en      (wr_en),
    .wr_addr    (wr_addr),
    .wr_data    (wr_data),
    .q_valid    (q_valid),
    .q_len      (q_len),
    .q_pop      (q_pop),
    .busy       (busy),
    .out_valid  (out_valid),
    .out_stall  (out_stall),
    .msg_byte   (msg_byte),
    .msg_last   (msg_last),
    .msg_length (msg_length)
  );

endmodule
